// ----- rtl/isrc_pkg.sv -----
// Shared types, widths and register codes for the image seam ramp correction block.
// Used by the top level and by the serial divider; depends on nothing else.
package isrc_pkg;

    // Field widths of the item channels and the register port.
    localparam int PIX_W      = 16;
    localparam int SPAN_W     = 13;
    localparam int DIST_W     = 11;
    localparam int TOT_W      = 32;
    localparam int ADJ_W      = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Largest span the ramp may use by default.
    localparam int MAX_SPAN_DEF = 4096;

    // Register values after reset.
    localparam logic [SPAN_W-1:0] SPAN_RST     = SPAN_W'(1024);
    localparam logic [PIX_W-1:0]  SAT_HIGH_RST = PIX_W'(60000);
    localparam logic [PIX_W-1:0]  SAT_LOW_RST  = PIX_W'(1);
    localparam logic [TOT_W-1:0]  LIMIT_RST    = TOT_W'(200000);

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SPAN       = 2'd0,
        CFG_SAT_HIGH   = 2'd1,
        CFG_SAT_LOW    = 2'd2,
        CFG_DIFF_LIMIT = 2'd3
    } cfg_index_t;

    // Status that the divider reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a signed sum to the unsigned sample range.
    function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [PIX_W+1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({2'b00, {PIX_W{1'b1}}})) begin
            res = {PIX_W{1'b1}};
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/isrc_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Depends on isrc_pkg for the status struct.
module isrc_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output isrc_pkg::div_stat_t  stat,
    output logic [NUM_W-1:0]     quot
);
    import isrc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    // One trial subtraction per cycle on the partial remainder.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
            rem_reg  <= '0;
            quo_reg  <= num;
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Done marks the edge at which the last quotient bit is stored.
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot      = quo_reg;

endmodule

// ----- rtl/image_seam_ramp_correction.sv -----
// Top level of the image seam ramp correction block: register port, sequencer
// and datapath. Depends on isrc_pkg and on the serial divider isrc_div.
//
// Usage: items enter on the s_ valid/ready channel and each gives exactly one
// result item on the m_ valid/ready channel. A measure item adds the absolute
// border difference to a saturating running total. A correct item replaces
// saturated border samples, then forms the ramp offset with one shared
// restoring divider that yields one quotient bit per cycle.
// A measure item goes through the prepare and final steps. A correct item goes
// through prepare, multiply and check, then the divide step if its offset
// applies, then the final step. NUM_W is the divider's dividend width, 16 plus
// the bits of the largest span.
// s_ready is high only while the sequencer is idle, so one item is in work at
// a time and no new item is accepted before the last one has left the final
// step; the next item is taken while a finished result still waits in the
// output register. If the receiver stalls, the finished item waits in the
// last step until the output register is free.
// Reset (synchronous, active low) clears the running total, the sequencer and
// m_valid, and loads the register defaults. Registers may be written only
// while the block is idle.
module image_seam_ramp_correction #(
    parameter int MAX_SPAN = isrc_pkg::MAX_SPAN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Register write port
    input  logic                                cfg_wr_en,
    input  logic [isrc_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [isrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [isrc_pkg::PIX_W-1:0]          s_first_border,
    input  logic [isrc_pkg::PIX_W-1:0]          s_second_border,
    input  logic [isrc_pkg::DIST_W-1:0]         s_distance,
    input  logic [isrc_pkg::PIX_W-1:0]          s_first_pixel,
    input  logic [isrc_pkg::PIX_W-1:0]          s_second_pixel,
    input  logic                                s_border_start,
    // Result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [isrc_pkg::TOT_W-1:0]          m_running_diff,
    output logic                                m_over_limit,
    output logic signed [isrc_pkg::ADJ_W-1:0]   m_adjust,
    output logic                                m_applies,
    output logic [isrc_pkg::PIX_W-1:0]          m_first_out,
    output logic [isrc_pkg::PIX_W-1:0]          m_second_out,
    output logic                                m_first_replaced,
    output logic                                m_second_replaced
);
    import isrc_pkg::*;

    // Span limit as far as the span register can reach, and derived widths.
    localparam int SPAN_REG_MAX = (1 << SPAN_W) - 1;
    localparam int SPAN_CAP     = (MAX_SPAN < SPAN_REG_MAX) ? MAX_SPAN : SPAN_REG_MAX;
    localparam int SP_W         = $clog2(SPAN_CAP + 1);
    localparam int NUM_W        = PIX_W + SP_W;
    localparam int DEN_W        = SP_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers and the running total.
    logic [SPAN_W-1:0] span_reg;
    logic [PIX_W-1:0]  sat_hi_reg;
    logic [PIX_W-1:0]  sat_lo_reg;
    logic [TOT_W-1:0]  limit_reg;
    logic [TOT_W-1:0]  total_reg;

    // Item held while it is worked on.
    logic              req_reg;
    logic              start_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [PIX_W-1:0]  fb_reg;
    logic [PIX_W-1:0]  sb_reg;
    logic [PIX_W-1:0]  pa_reg;
    logic [PIX_W-1:0]  pb_reg;

    // Intermediate values.
    logic [SP_W-1:0]   sp_reg;
    logic              neg_reg;
    logic [PIX_W-1:0]  absd_reg;
    logic              frep_reg;
    logic              srep_reg;
    logic              in_range_reg;
    logic [NUM_W-1:0]  mag_reg;
    logic              applies_reg;

    // Output register.
    logic                    m_valid_reg;
    logic [TOT_W-1:0]        out_total_reg;
    logic                    out_over_reg;
    logic signed [ADJ_W-1:0] out_adj_reg;
    logic                    out_applies_reg;
    logic [PIX_W-1:0]        out_first_reg;
    logic [PIX_W-1:0]        out_second_reg;
    logic                    out_frep_reg;
    logic                    out_srep_reg;

    // Combinational helpers.
    logic [SP_W-1:0]         sp_next;
    logic                    frep_next;
    logic                    srep_next;
    logic [PIX_W-1:0]        fb_fix;
    logic [PIX_W-1:0]        sb_fix;
    logic                    neg_next;
    logic [PIX_W-1:0]        absd_next;
    logic [SP_W-1:0]         span_left;
    logic [NUM_W-1:0]        mag_next;
    logic                    in_range_next;
    logic                    prev_ok;
    logic                    apply_next;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    div_stat_t               div_stat;
    logic [NUM_W-1:0]        div_quot;
    logic [ADJ_W-1:0]        adj_mag;
    logic signed [ADJ_W-1:0] adj_next;
    logic [TOT_W-1:0]        total_base;
    logic [TOT_W:0]          total_sum;
    logic [TOT_W-1:0]        total_next;
    logic                    out_free;
    logic                    fin_fire;

    // Span clamp, border replacement and absolute difference.
    always_comb begin
        if (span_reg < SPAN_W'(2)) begin
            sp_next = SP_W'(2);
        end else if (32'(span_reg) > 32'(SPAN_CAP)) begin
            sp_next = SP_W'(SPAN_CAP);
        end else begin
            sp_next = SP_W'(span_reg);
        end
        // Measure items compare raw samples, so replacement is gated off.
        frep_next = req_reg && ((fb_reg > sat_hi_reg) || (fb_reg < sat_lo_reg));
        srep_next = req_reg && ((sb_reg > sat_hi_reg) || (sb_reg < sat_lo_reg));
        fb_fix    = frep_next ? sb_reg : fb_reg;
        sb_fix    = srep_next ? fb_fix : sb_reg;
        neg_next  = sb_fix > fb_fix;
        absd_next = neg_next ? (sb_fix - fb_fix) : (fb_fix - sb_fix);
    end

    // Ramp numerator and distance check.
    always_comb begin
        span_left     = SP_W'(32'(sp_reg) - 32'(dist_reg));
        mag_next      = NUM_W'(absd_reg) * NUM_W'(span_left);
        in_range_next = 32'(dist_reg) < 32'(sp_reg >> 1);
    end

    // The offset one step closer to the seam is nonzero when its numerator
    // reaches the span; that numerator is this one plus the difference.
    always_comb begin
        prev_ok    = (dist_reg == '0) ||
                     ((NUM_W+1)'(mag_reg) + (NUM_W+1)'(absd_reg) >= (NUM_W+1)'(sp_reg));
        apply_next = in_range_reg && (absd_reg >= PIX_W'(2)) && prev_ok;
        div_start  = (state_reg == ST_CHK) && apply_next;
        // Rounded offset is floor((num + span) / (2 * span)).
        div_num    = mag_reg + NUM_W'(sp_reg);
        div_den    = {sp_reg, 1'b0};
    end

    // Final offset, totals and output availability.
    always_comb begin
        adj_mag    = applies_reg ? {1'b0, div_quot[PIX_W-1:0]} : '0;
        adj_next   = neg_reg ? -$signed(adj_mag) : $signed(adj_mag);
        total_base = start_reg ? '0 : total_reg;
        total_sum  = (TOT_W+1)'(total_base) + (TOT_W+1)'(absd_reg);
        if (req_reg) begin
            total_next = total_reg;
        end else if (total_sum[TOT_W]) begin
            total_next = {TOT_W{1'b1}};
        end else begin
            total_next = total_sum[TOT_W-1:0];
        end
        out_free = !m_valid_reg || m_ready;
        fin_fire = (state_reg == ST_FIN) && out_free;
    end

    isrc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // Sequencer, registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
            span_reg    <= SPAN_RST;
            sat_hi_reg  <= SAT_HIGH_RST;
            sat_lo_reg  <= SAT_LOW_RST;
            limit_reg   <= LIMIT_RST;
        end else begin
            // Register writes.
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SPAN:       span_reg   <= cfg_wdata[SPAN_W-1:0];
                    CFG_SAT_HIGH:   sat_hi_reg <= cfg_wdata[PIX_W-1:0];
                    CFG_SAT_LOW:    sat_lo_reg <= cfg_wdata[PIX_W-1:0];
                    CFG_DIFF_LIMIT: limit_reg  <= cfg_wdata[TOT_W-1:0];
                endcase
            end

            // The output register fills when a result is formed and empties on a handshake.
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_req_type;
                        start_reg <= s_border_start && !s_req_type;
                        dist_reg  <= s_distance;
                        fb_reg    <= s_first_border;
                        sb_reg    <= s_second_border;
                        pa_reg    <= s_first_pixel;
                        pb_reg    <= s_second_pixel;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    sp_reg      <= sp_next;
                    frep_reg    <= frep_next;
                    srep_reg    <= srep_next;
                    neg_reg     <= neg_next;
                    absd_reg    <= absd_next;
                    applies_reg <= 1'b0;
                    // At the seam itself the replaced borders are corrected.
                    if (dist_reg == '0) begin
                        pa_reg <= fb_fix;
                        pb_reg <= sb_fix;
                    end
                    state_reg <= req_reg ? ST_MUL : ST_FIN;
                end
                ST_MUL: begin
                    mag_reg      <= mag_next;
                    in_range_reg <= in_range_next;
                    state_reg    <= ST_CHK;
                end
                ST_CHK: begin
                    applies_reg <= apply_next;
                    state_reg   <= apply_next ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        total_reg       <= total_next;
                        out_total_reg   <= total_next;
                        out_over_reg    <= total_next > limit_reg;
                        out_adj_reg     <= req_reg ? adj_next : '0;
                        out_applies_reg <= req_reg && applies_reg;
                        out_first_reg   <= req_reg ?
                            clamp_pix($signed({2'b00, pa_reg}) + $signed({adj_next[ADJ_W-1], adj_next}))
                            : '0;
                        out_second_reg  <= req_reg ?
                            clamp_pix($signed({2'b00, pb_reg}) - $signed({adj_next[ADJ_W-1], adj_next}))
                            : '0;
                        out_frep_reg    <= frep_reg;
                        out_srep_reg    <= srep_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_running_diff    = out_total_reg;
    assign m_over_limit      = out_over_reg;
    assign m_adjust          = out_adj_reg;
    assign m_applies         = out_applies_reg;
    assign m_first_out       = out_first_reg;
    assign m_second_out      = out_second_reg;
    assign m_first_replaced  = out_frep_reg;
    assign m_second_replaced = out_srep_reg;

`ifndef SYNTH
    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    // No new item is taken while the divider is working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    // An accepted item closes the input until its result is formed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input stayed ready after an accepted item");

    // A result without an applied offset carries no offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_applies) |-> (m_adjust == '0))
        else $error("nonzero offset on a result that does not apply it");
`endif

endmodule
